[src/ipv4p_pkg.sv]
// ============================================================================
// ipv4p_pkg: shared types and constants for the dotted IPv4 text parser
// Holds the character class record that the classifier and the accumulator
// both use, and the text constants that the classifier uses.
// ============================================================================
`default_nettype none

package ipv4p_pkg;

   localparam logic [7:0] PERIOD_CHAR    = 8'h2E;
   localparam logic [7:0] DIGIT_ZERO     = 8'h30;
   localparam logic [7:0] DIGIT_NINE     = 8'h39;
   localparam logic [2:0] PERIODS_NEEDED = 3'd3;
   localparam logic [2:0] MAX_COUNT      = 3'd4;
   localparam int         ADDR_W         = 32;

   typedef struct packed {
      logic       is_digit;
      logic       is_period;
      logic [3:0] digit;
   } char_class_type;

   typedef struct packed {
      logic              valid_res;
      logic [ADDR_W-1:0] address;
   } parse_result_type;

endpackage : ipv4p_pkg

`default_nettype wire

[src/ipv4_dotted_text_parser_unit.sv]
// ============================================================================
// ipv4_dotted_text_parser_unit: dotted-decimal IPv4 text to binary address
// Takes one text byte per request with a last flag and returns one response
// per text holding a validity bit and the 32-bit address.
// ============================================================================
//
//   Channel   Ports                                   Direction  Moves
//   req       req_valid req_stall req_character       in         one byte
//             req_last
//   rsp       rsp_valid rsp_stall rsp_valid_res       out        one result
//             rsp_address
//
// A request is registered in the input register and folded into the parse
// state once the output register is free or being drained; a final byte
// then places its response in the output register, which drives the
// outputs. One byte is taken every cycle while the output register is free
// or being drained. Reset is synchronous and clears the parse state and both
// valid flags. A stalled response holds the output register, and req_stall
// rises only while a byte waits in the input register behind it.
// ============================================================================
`default_nettype none

module ipv4_dotted_text_parser_unit
   import ipv4p_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [7:0]        req_character,
   input  wire logic              req_last,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic              rsp_valid_res,
   output      logic [ADDR_W-1:0] rsp_address
);

   // Input register: one byte waiting to be folded into the state.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;
   logic       in_last_ff, in_last_in;

   // Output register: one finished response.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_res_ff, rsp_res_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   logic             advance;
   logic             fire;
   logic             take;
   char_class_type   cls;
   parse_result_type result;

   // The processing stage may move whenever the output register is free or
   // is being emptied this cycle.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   ipv4p_char_classifier u_classifier (
      .character (in_char_ff),
      .cls       (cls)
   );

   ipv4p_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .cls    (cls),
      .last   (in_last_ff),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_last_in  = in_last_ff;
      if (take) begin
         in_valid_in = 1'b1;
         in_char_in  = req_character;
         in_last_in  = req_last;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (fire && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = result.valid_res;
         rsp_addr_in  = result.address;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_char_ff  <= in_char_in;
      in_last_ff  <= in_last_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;
   assign rsp_address   = rsp_addr_ff;

   // An invalid text always reports a zero address.
   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_address == '0))
      else $error("invalid response carries a nonzero address");

   // Back-pressure on requests only arises with a byte held in the input stage.
   a_stall_needs_byte : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with an empty input register");

   // Folding a final byte produces a response at the next edge.
   a_last_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      (fire && in_last_ff) |=> rsp_valid)
      else $error("final byte processed without a response");

endmodule : ipv4_dotted_text_parser_unit

`default_nettype wire

[src/ipv4p_char_classifier.sv]
// ============================================================================
// ipv4p_char_classifier: sorts one text byte into digit, period or other
// Also gives the binary value of a digit.
// ============================================================================
`default_nettype none

module ipv4p_char_classifier
   import ipv4p_pkg::*;
(
   input  wire logic [7:0]     character,
   output char_class_type      cls
);

   // The low nibble of an ASCII digit is its value.
   always_comb begin
      cls.is_digit  = (character inside {[DIGIT_ZERO:DIGIT_NINE]});
      cls.is_period = (character == PERIOD_CHAR);
      cls.digit     = character[3:0];
   end

endmodule : ipv4p_char_classifier

`default_nettype wire

[src/ipv4p_accum.sv]
// ============================================================================
// ipv4p_accum: running parse state and end-of-text result
// Folds one classified character per strobe into the digit run, the address
// sum and the period and error tallies, and returns to the cleared state
// after the final character of a text.
// ============================================================================
`default_nettype none

module ipv4p_accum
   import ipv4p_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire char_class_type   cls,
   input  wire logic             last,
   output parse_result_type      result
);

   logic [ADDR_W-1:0] sum_ff, sum_in;
   logic [ADDR_W-1:0] run_ff, run_in;
   logic              in_run_ff, in_run_in;
   logic [2:0]        runs_ff, runs_in;
   logic [2:0]        periods_ff, periods_in;
   logic              bad_ff, bad_in;

   logic [ADDR_W-1:0] run_upd, shifted, sum_upd;
   logic              in_run_upd, do_close, add_run;
   logic [2:0]        runs_upd, periods_upd;
   logic              bad_upd, ok;

   always_comb begin
      // A digit extends the run (times ten as shift-and-add, wrapping).
      run_upd    = cls.is_digit
                   ? ((run_ff << 3) + (run_ff << 1) + {28'd0, cls.digit})
                   : run_ff;
      in_run_upd = cls.is_digit | in_run_ff;

      // A run closes on any non-digit, and on the final character of a text.
      do_close = !cls.is_digit || last;
      add_run  = do_close && in_run_upd && (runs_ff < MAX_COUNT);

      case (runs_ff[1:0])
         2'd0:    shifted = run_upd << 24;
         2'd1:    shifted = run_upd << 16;
         2'd2:    shifted = run_upd << 8;
         default: shifted = run_upd;
      endcase

      sum_upd  = add_run ? (sum_ff + shifted) : sum_ff;
      runs_upd = add_run ? (runs_ff + 3'd1) : runs_ff;

      periods_upd = (cls.is_period && (periods_ff < MAX_COUNT))
                    ? (periods_ff + 3'd1) : periods_ff;
      bad_upd     = bad_ff | !(cls.is_digit | cls.is_period);

      ok               = !bad_upd && (periods_upd == PERIODS_NEEDED);
      result.valid_res = ok;
      result.address   = ok ? sum_upd : '0;

      sum_in     = sum_ff;
      run_in     = run_ff;
      in_run_in  = in_run_ff;
      runs_in    = runs_ff;
      periods_in = periods_ff;
      bad_in     = bad_ff;
      if (fire) begin
         if (last) begin
            sum_in     = '0;
            run_in     = '0;
            in_run_in  = 1'b0;
            runs_in    = '0;
            periods_in = '0;
            bad_in     = 1'b0;
         end else begin
            sum_in     = sum_upd;
            run_in     = do_close ? '0 : run_upd;
            in_run_in  = do_close ? 1'b0 : in_run_upd;
            runs_in    = runs_upd;
            periods_in = periods_upd;
            bad_in     = bad_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         run_ff     <= '0;
         in_run_ff  <= 1'b0;
         runs_ff    <= '0;
         periods_ff <= '0;
         bad_ff     <= 1'b0;
      end else begin
         sum_ff     <= sum_in;
         run_ff     <= run_in;
         in_run_ff  <= in_run_in;
         runs_ff    <= runs_in;
         periods_ff <= periods_in;
         bad_ff     <= bad_in;
      end
   end

endmodule : ipv4p_accum

`default_nettype wire
